/* rtl/mfm_pkg.sv */
package mfm_pkg;

  localparam int unsigned DIM   = 4;
  localparam int unsigned WORD  = 32;
  localparam int unsigned ROWW  = DIM * WORD;
  localparam logic [1:0]  LAST_ROW = 2'd3;
  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

  // One queued input row, tagged by the front end.
  typedef struct packed {
    logic [1:0]      row;
    logic            trig;
    logic [ROWW-1:0] first;
    logic [ROWW-1:0] second;
  } mfm_item_t;

  // Request and response of the shared float unit.
  typedef struct packed {
    logic        start;
    logic        is_add;
    logic [31:0] a;
    logic [31:0] b;
  } mfm_fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } mfm_fpu_rsp_t;

endpackage

/* rtl/matrix4x4_float_multiply_core.sv */
// Single-precision 4x4 matrix multiply. Each input beat carries one row
// index (in_tuser) and that row of both operands; rows are kept in two
// row-wide stores and stay there across products, so a later product may
// resend only the rows that changed. A beat for row 3 triggers the product:
// four output beats follow, rows 0 to 3 in order, with tlast on row 3.
// With the swap register clear the product is first times second, with it
// set second times first. Every element is ((p0+p1)+p2)+p3 with each
// product and sum rounded to nearest-even on its own (no fused
// multiply-add, subnormals kept), and any NaN comes out as 0x7FC00000.
// A beat for rows 0 to 2 is only written into the stores. A row-3
// beat also starts the product on the single shared float unit, which
// performs all 64 multiplies and 48 adds in turn, with one store read
// before each multiply (special operands finish sooner). A two-beat
// queue sits in front, so the input side accepts up to two further
// beats while a product is computed, and the result register lets the
// next row proceed while a finished row waits for out_tready. Write
// swap only while idle.
module matrix4x4_float_multiply_core (
  input  logic         clk,
  input  logic         rst_n,
  // Configuration: cfg_data[0] = swap_operands.
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_data,
  // Input rows.
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata, low to high: first_col0..first_col3, second_col0..second_col3.
  input  logic [255:0] in_tdata,
  // in_tuser: row_index.
  input  logic [1:0]   in_tuser,
  // Product rows.
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata, low to high: prod_col0..prod_col3.
  output logic [127:0] out_tdata,
  // out_tuser: out_row.
  output logic [1:0]   out_tuser,
  // out_tlast: last_row.
  output logic         out_tlast
);
  import mfm_pkg::*;

  logic      swap_r, swap_nxt;
  logic      q_valid, q_ready;
  mfm_item_t q_item;

  assign cfg_ready = 1'b1;
  assign swap_nxt  = (cfg_valid && cfg_ready) ? cfg_data[0] : swap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else begin
      swap_r <= swap_nxt;
    end
  end

  mfm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  mfm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .swap       (swap_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/mfm_front.sv */
module mfm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_tuser,
  input  logic [255:0]        in_tdata,
  output logic                q_valid,
  input  logic                q_ready,
  output mfm_pkg::mfm_item_t  q_item
);
  import mfm_pkg::*;

  mfm_item_t  buf_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  mfm_item_t  item_in;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_item    = buf_r[rd_ptr_r];
  assign push      = in_tvalid & in_tready;
  assign pop       = q_valid & q_ready;

  always_comb begin
    item_in.row    = in_tuser;
    item_in.trig   = (in_tuser == LAST_ROW);
    item_in.first  = in_tdata[ROWW-1:0];
    item_in.second = in_tdata[2*ROWW-1:ROWW];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

/* rtl/mfm_fpu.sv */
module mfm_fpu (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mfm_pkg::mfm_fpu_req_t req,
  output mfm_pkg::mfm_fpu_rsp_t rsp
);
  import mfm_pkg::*;

  typedef enum logic [7:0] {
    F_IDLE = 8'b0000_0001,
    F_PREP = 8'b0000_0010,
    F_ALN  = 8'b0000_0100,
    F_SUM  = 8'b0000_1000,
    F_LZC  = 8'b0001_0000,
    F_SHL  = 8'b0010_0000,
    F_DEN  = 8'b0100_0000,
    F_RND  = 8'b1000_0000
  } fstate_t;

  fstate_t            st_r, st_nxt;
  logic               is_add_r, is_add_nxt;
  logic [31:0]        a_r, a_nxt, b_r, b_nxt;
  logic               sgn_r, sgn_nxt;
  logic signed [10:0] ex_r, ex_nxt;
  logic [50:0]        m_r, m_nxt;
  logic [5:0]         lz_r, lz_nxt;
  logic [23:0]        big_m_r, big_m_nxt, sm_m_r, sm_m_nxt;
  logic [7:0]         big_e_r, big_e_nxt, d_r, d_nxt;
  logic               sub_r, sub_nxt;
  logic [31:0]        res_r, res_nxt;
  logic               done_r, done_nxt;

  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [47:0] prod;
  logic [49:0] mb50, shr50, lostmask;
  logic [50:0] bigx, alx, sum51, shr51, lost51;
  logic [10:0] dsh;
  logic [30:0] rbits;
  logic        inc;

  function automatic logic [5:0] clz51(input logic [50:0] v);
    logic [5:0] n;
    n = 6'd51;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) begin
        n = 6'(50 - i);
      end
    end
    return n;
  endfunction

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  always_comb begin
    ea     = (a_r[30:23] == 8'd0) ? 8'd1 : a_r[30:23];
    eb     = (b_r[30:23] == 8'd0) ? 8'd1 : b_r[30:23];
    ma     = {(a_r[30:23] != 8'd0), a_r[22:0]};
    mb     = {(b_r[30:23] != 8'd0), b_r[22:0]};
    a_nan  = (a_r[30:23] == 8'hFF) && (a_r[22:0] != 23'd0);
    b_nan  = (b_r[30:23] == 8'hFF) && (b_r[22:0] != 23'd0);
    a_inf  = (a_r[30:23] == 8'hFF) && (a_r[22:0] == 23'd0);
    b_inf  = (b_r[30:23] == 8'hFF) && (b_r[22:0] == 23'd0);
    a_zero = (a_r[30:0] == 31'd0);
    b_zero = (b_r[30:0] == 31'd0);
    prod   = ma * mb;

    mb50     = {sm_m_r, 26'd0};
    shr50    = mb50 >> d_r;
    lostmask = ~({50{1'b1}} << d_r);

    bigx  = {1'b0, big_m_r, 26'd0};
    alx   = {1'b0, m_r[49:0]};
    sum51 = sub_r ? (bigx - alx) : (bigx + alx);

    dsh    = 11'sd1 - ex_r;
    shr51  = m_r >> dsh[5:0];
    lost51 = m_r & ~({51{1'b1}} << dsh[5:0]);

    inc   = m_r[26] & ((|m_r[25:0]) | m_r[27]);
    rbits = {ex_r[7:0], m_r[49:27]} + {30'd0, inc};

    st_nxt     = st_r;
    is_add_nxt = is_add_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    sgn_nxt    = sgn_r;
    ex_nxt     = ex_r;
    m_nxt      = m_r;
    lz_nxt     = lz_r;
    big_m_nxt  = big_m_r;
    sm_m_nxt   = sm_m_r;
    big_e_nxt  = big_e_r;
    d_nxt      = d_r;
    sub_nxt    = sub_r;
    res_nxt    = res_r;
    done_nxt   = 1'b0;

    case (st_r)
      F_IDLE: begin
        if (req.start) begin
          a_nxt      = req.a;
          b_nxt      = req.b;
          is_add_nxt = req.is_add;
          st_nxt     = F_PREP;
        end
      end
      F_PREP: begin
        if (!is_add_r) begin
          sgn_nxt = a_r[31] ^ b_r[31];
          if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            res_nxt  = CANON_NAN;
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else if (a_inf || b_inf) begin
            res_nxt  = {a_r[31] ^ b_r[31], 8'hFF, 23'd0};
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else if (a_zero || b_zero) begin
            res_nxt  = {a_r[31] ^ b_r[31], 31'd0};
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else begin
            m_nxt  = {prod, 3'd0};
            ex_nxt = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
            st_nxt = F_LZC;
          end
        end else begin
          if (a_nan || b_nan || (a_inf && b_inf && (a_r[31] != b_r[31]))) begin
            res_nxt  = CANON_NAN;
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else if (a_inf) begin
            res_nxt  = {a_r[31], 8'hFF, 23'd0};
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else if (b_inf) begin
            res_nxt  = {b_r[31], 8'hFF, 23'd0};
            done_nxt = 1'b1;
            st_nxt   = F_IDLE;
          end else begin
            // Finite magnitudes order like their bit patterns.
            sub_nxt = a_r[31] ^ b_r[31];
            if (a_r[30:0] >= b_r[30:0]) begin
              sgn_nxt   = a_r[31];
              big_m_nxt = ma;
              big_e_nxt = ea;
              sm_m_nxt  = mb;
              d_nxt     = ea - eb;
            end else begin
              sgn_nxt   = b_r[31];
              big_m_nxt = mb;
              big_e_nxt = eb;
              sm_m_nxt  = ma;
              d_nxt     = eb - ea;
            end
            st_nxt = F_ALN;
          end
        end
      end
      F_ALN: begin
        if (d_r >= 8'd50) begin
          m_nxt = {50'd0, |sm_m_r};
        end else begin
          m_nxt = {1'b0, shr50[49:1], shr50[0] | (|(mb50 & lostmask))};
        end
        st_nxt = F_SUM;
      end
      F_SUM: begin
        m_nxt  = sum51;
        ex_nxt = $signed({3'd0, big_e_r}) + 11'sd1;
        if (sum51 == 51'd0) begin
          // Exact cancellation gives +0; equal-signed zeros keep their sign.
          res_nxt  = {sub_r ? 1'b0 : sgn_r, 31'd0};
          done_nxt = 1'b1;
          st_nxt   = F_IDLE;
        end else begin
          st_nxt = F_LZC;
        end
      end
      F_LZC: begin
        lz_nxt = clz51(m_r);
        st_nxt = F_SHL;
      end
      F_SHL: begin
        m_nxt  = m_r << lz_r;
        ex_nxt = ex_r - $signed({5'd0, lz_r});
        st_nxt = F_DEN;
      end
      F_DEN: begin
        if (ex_r <= 11'sd0) begin
          if (dsh >= 11'd51) begin
            m_nxt = {50'd0, |m_r};
          end else begin
            m_nxt = {shr51[50:1], shr51[0] | (|lost51)};
          end
          ex_nxt = 11'sd0;
        end
        st_nxt = F_RND;
      end
      F_RND: begin
        if (ex_r >= 11'sd255) begin
          res_nxt = {sgn_r, 8'hFF, 23'd0};
        end else begin
          res_nxt = {sgn_r, rbits};
        end
        done_nxt = 1'b1;
        st_nxt   = F_IDLE;
      end
      default: begin
        st_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= F_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_add_r <= is_add_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    sgn_r    <= sgn_nxt;
    ex_r     <= ex_nxt;
    m_r      <= m_nxt;
    lz_r     <= lz_nxt;
    big_m_r  <= big_m_nxt;
    sm_m_r   <= sm_m_nxt;
    big_e_r  <= big_e_nxt;
    d_r      <= d_nxt;
    sub_r    <= sub_nxt;
    res_r    <= res_nxt;
  end

endmodule

/* rtl/mfm_back.sv */
module mfm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                swap,
  input  logic                q_valid,
  output logic                q_ready,
  input  mfm_pkg::mfm_item_t  q_item,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [127:0]        out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import mfm_pkg::*;

  typedef enum logic [6:0] {
    B_IDLE = 7'b000_0001,
    B_RD   = 7'b000_0010,
    B_MUL  = 7'b000_0100,
    B_MWT  = 7'b000_1000,
    B_ADD  = 7'b001_0000,
    B_AWT  = 7'b010_0000,
    B_OUT  = 7'b100_0000
  } bstate_t;

  bstate_t      st_r, st_nxt;
  logic [1:0]   i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [31:0]  acc_r, acc_nxt, prod_r, prod_nxt;
  logic [31:0]  col_r [DIM];
  logic         col_we;
  logic [31:0]  col_val;
  logic         ov_r, ov_nxt;
  logic [127:0] od_r;
  logic [1:0]   orow_r;
  logic         olast_r;
  logic         oload;

  logic [ROWW-1:0] mem_a [DIM];
  logic [ROWW-1:0] mem_b [DIM];
  logic [ROWW-1:0] rd_a_r, rd_b_r;
  logic [1:0]      addr_a, addr_b;
  logic [31:0]     lw, rw;

  mfm_fpu_req_t req;
  mfm_fpu_rsp_t rsp;

  mfm_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign q_ready    = (st_r == B_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = orow_r;
  assign out_tlast  = olast_r;

  // Left operand element (i,k), right operand element (k,j).
  assign addr_a = swap ? k_r : i_r;
  assign addr_b = swap ? i_r : k_r;

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      mem_a[q_item.row] <= q_item.first;
      mem_b[q_item.row] <= q_item.second;
    end
    rd_a_r <= mem_a[addr_a];
    rd_b_r <= mem_b[addr_b];
  end

  always_comb begin
    lw = swap ? rd_b_r[k_r*WORD +: WORD] : rd_a_r[k_r*WORD +: WORD];
    rw = swap ? rd_a_r[j_r*WORD +: WORD] : rd_b_r[j_r*WORD +: WORD];

    st_nxt   = st_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    prod_nxt = prod_r;
    col_we   = 1'b0;
    col_val  = rsp.res;
    oload    = 1'b0;
    req      = '0;

    case (st_r)
      B_IDLE: begin
        if (q_valid && q_item.trig) begin
          i_nxt  = 2'd0;
          j_nxt  = 2'd0;
          k_nxt  = 2'd0;
          st_nxt = B_RD;
        end
      end
      B_RD: begin
        st_nxt = B_MUL;
      end
      B_MUL: begin
        req.start  = 1'b1;
        req.is_add = 1'b0;
        req.a      = lw;
        req.b      = rw;
        st_nxt     = B_MWT;
      end
      B_ADD: begin
        req.start  = 1'b1;
        req.is_add = 1'b1;
        req.a      = acc_r;
        req.b      = prod_r;
        st_nxt     = B_AWT;
      end
      B_MWT, B_AWT: begin
        if (rsp.done) begin
          if ((st_r == B_MWT) && (k_r != 2'd0)) begin
            prod_nxt = rsp.res;
            st_nxt   = B_ADD;
          end else begin
            acc_nxt = rsp.res;
            if (k_r == 2'(DIM - 1)) begin
              col_we = 1'b1;
              k_nxt  = 2'd0;
              if (j_r == 2'(DIM - 1)) begin
                st_nxt = B_OUT;
              end else begin
                j_nxt  = j_r + 2'd1;
                st_nxt = B_RD;
              end
            end else begin
              k_nxt  = k_r + 2'd1;
              st_nxt = B_RD;
            end
          end
        end
      end
      B_OUT: begin
        if (!ov_r || out_tready) begin
          oload = 1'b1;
          j_nxt = 2'd0;
          k_nxt = 2'd0;
          if (i_r == LAST_ROW) begin
            st_nxt = B_IDLE;
          end else begin
            i_nxt  = i_r + 2'd1;
            st_nxt = B_RD;
          end
        end
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase

    ov_nxt = oload ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (col_we) begin
      col_r[j_r] <= col_val;
    end
    if (oload) begin
      od_r    <= {col_r[3], col_r[2], col_r[1], col_r[0]};
      orow_r  <= i_r;
      olast_r <= (i_r == LAST_ROW);
    end
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Testbench for the 4x4 single-precision matrix multiply core.
// Rows of both operands are streamed in, and each row-3 beat must yield four
// product rows. A local predictor keeps its own copy of both row stores and
// of the swap register. It evaluates every element as ((p0+p1)+p2)+p3, with
// each step rounded to nearest-even single precision. Each product and sum
// is formed in double precision, which is exact enough that a second rounding
// to single gives the correctly rounded single result. Results are checked
// in order as they leave the core.
module testbench;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;   // first_col0..3, second_col0..3
  logic [1:0]   in_tuser = '0;   // row_index
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // prod_col0..3
  logic [1:0]   out_tuser;       // out_row
  logic         out_tlast;       // last_row

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef struct packed {
    logic [1:0]   row;
    logic [127:0] cols;
    logic         last;
  } prod_row_t;

  // Predictor state.
  logic [31:0] first_rows  [16];
  logic [31:0] second_rows [16];
  logic        swap_q = 1'b0;
  prod_row_t   pending_rows [$];

  int errors = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;

  matrix4x4_float_multiply_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // Widen a single to a double exactly, subnormals included.
  function automatic real sp_to_real(logic [31:0] b);
    logic [63:0] d;
    logic [22:0] m;
    int p;
    m = b[22:0];
    if (b[30:23] == 8'hFF) begin
      d = {b[31], 11'h7FF, m, 29'd0};
    end else if (b[30:23] == 8'h00) begin
      if (m == 0) begin
        d = {b[31], 63'd0};
      end else begin
        p = 22;
        while (!m[p]) p--;
        d = {b[31], 11'(p - 149 + 1023), 52'(64'(m) << (52 - p))};
      end
    end else begin
      d = {b[31], 11'(b[30:23] + 896), m, 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // Round a double to single precision, nearest-even, with gradual underflow.
  function automatic logic [31:0] real_to_sp(real r);
    logic [63:0] d, sig, kept, rem, half;
    logic s;
    int e, sh;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN : {s, 8'hFF, 23'd0};
    if (d[62:52] == 11'h000) return {s, 31'd0};
    e = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) return {s, 31'd0};
    kept = sig >> sh;
    rem = sig & ((64'd1 << sh) - 1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept++;
    if (e >= -126) begin
      if (kept[24]) begin
        kept >>= 1;
        e++;
      end
      if (e > 127) return {s, 8'hFF, 23'd0};
      return {s, 8'(e + 127), kept[22:0]};
    end
    // A subnormal that rounds up into the smallest normal encodes correctly too.
    return {s, kept[30:0]};
  endfunction

  function automatic logic [31:0] sp_mul(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  function automatic logic [31:0] sp_add(logic [31:0] a, logic [31:0] b);
    return real_to_sp(sp_to_real(a) + sp_to_real(b));
  endfunction

  // Store the accepted row and, on row 3, queue the four product rows.
  task automatic predict_product(logic [1:0] row, logic [255:0] data);
    logic [31:0] lm [16];
    logic [31:0] rm [16];
    logic [31:0] acc;
    prod_row_t pr;
    for (int c = 0; c < 4; c++) begin
      first_rows[row * 4 + c]  = data[32 * c +: 32];
      second_rows[row * 4 + c] = data[128 + 32 * c +: 32];
    end
    if (row != 2'd3) return;
    for (int n = 0; n < 16; n++) begin
      lm[n] = swap_q ? second_rows[n] : first_rows[n];
      rm[n] = swap_q ? first_rows[n] : second_rows[n];
    end
    for (int i = 0; i < 4; i++) begin
      pr.row = 2'(i);
      pr.last = (i == 3);
      for (int j = 0; j < 4; j++) begin
        acc = sp_mul(lm[i * 4], rm[j]);
        for (int k = 1; k < 4; k++)
          acc = sp_add(acc, sp_mul(lm[i * 4 + k], rm[k * 4 + j]));
        pr.cols[32 * j +: 32] = acc;
      end
      pending_rows.push_back(pr);
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Send one row beat. The valid line stays high across back-to-back beats;
  // this task lowers it only for a chosen idle gap, and wait_idle lowers it.
  task automatic send_row(logic [1:0] row, logic [31:0] f [4], logic [31:0] s [4]);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = row;
    in_tdata = {s[3], s[2], s[1], s[0], f[3], f[2], f[1], f[0]};
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    predict_product(row, in_tdata);
  endtask

  // Wait until the product is done and the input queue has drained.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_swap(logic v);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    swap_q = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random operand: raw bits, moderate values, subnormals, or specials.
  function automatic logic [31:0] rand_float();
    logic [31:0] pick [8];
    pick = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
             32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000};
    case ($urandom_range(9))
      0, 1: return $urandom();
      2:    return {1'($urandom()), 8'h00, 23'($urandom())};
      3:    return pick[$urandom_range(7)];
      default: return {1'($urandom()), 8'($urandom_range(140, 114)), 23'($urandom())};
    endcase
  endfunction

  task automatic send_random_row(logic [1:0] row);
    logic [31:0] f [4];
    logic [31:0] s [4];
    for (int c = 0; c < 4; c++) begin
      f[c] = rand_float();
      s[c] = rand_float();
    end
    send_row(row, f, s);
  endtask

  task automatic test_directed();
    logic [31:0] one [4];
    logic [31:0] f [4];
    logic [31:0] s [4];
    // Identity times a matrix of distinct values, with swap clear.
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        one[c] = (c == r) ? 32'h3F80_0000 : 32'h0000_0000;
        f[c] = 32'h4000_0000 + 32'(r * 4 + c) * 32'h0008_0000;
      end
      send_row(2'(r), one, f);
    end
    // Special values: infinities, NaN, zero times infinity, signed zeros,
    // subnormals, overflow of the largest value, and rounding ties.
    f = '{32'h7F80_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};
    s = '{32'h0000_0000, 32'hFF80_0000, 32'h3F80_0000, 32'h8000_0000};
    send_row(2'd0, f, s);
    f = '{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h807F_FFFF};
    s = '{32'h4000_0000, 32'hFF7F_FFFF, 32'h3F00_0000, 32'h0080_0000};
    send_row(2'd1, f, s);
    f = '{32'h3F80_0001, 32'h3F80_0001, 32'h3380_0000, 32'hB380_0000};
    s = '{32'h3F80_0001, 32'h3F7F_FFFF, 32'h0000_0001, 32'h3400_0000};
    send_row(2'd2, f, s);
    f = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000};
    s = '{32'h7FFF_FFFF, 32'h0040_0000, 32'h7F80_0000, 32'h7F80_0000};
    send_row(2'd3, f, s);
    // Swap set: a new row 3 reuses the stored rows 0 to 2 for the reverse
    // product, then a partial update of row 1 reuses the other stored rows.
    write_swap(1'b1);
    send_random_row(2'd3);
    send_random_row(2'd1);
    send_random_row(2'd3);
    write_swap(1'b0);
    send_random_row(2'd3);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, logic swap, int count);
    int sent;
    int pick;
    logic [1:0] order [3];
    wait_idle();
    write_swap(swap);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        // Full matrix: rows 0 to 2 in random order, then row 3.
        order = '{2'd0, 2'd1, 2'd2};
        order.shuffle();
        foreach (order[k]) send_random_row(order[k]);
        send_random_row(2'd3);
        sent += 4;
      end else if (pick < 9) begin
        // Partial update of the stored matrices.
        for (int r = 0; r < 3; r++)
          if ($urandom_range(1)) begin
            send_random_row(2'(r));
            sent++;
          end
        send_random_row(2'd3);
        sent++;
      end else begin
        // Noise: any rows, repeats allowed.
        repeat ($urandom_range(4, 1)) begin
          send_random_row(2'($urandom_range(3)));
          sent++;
        end
      end
    end
    in_idle_pct = 0;
    out_stall_pct = 0;
  endtask

  // Receiver stalls.
  always @(negedge clk) out_tready <= ($urandom_range(99) >= out_stall_pct);

  // Compare each product row with the oldest expectation.
  always @(posedge clk) begin
    prod_row_t exp_row;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_rows.size() == 0) begin
        report_mismatch($sformatf("unexpected row %0d", out_tuser));
      end else begin
        exp_row = pending_rows.pop_front();
        if (out_tuser !== exp_row.row)
          report_mismatch($sformatf("row %0d, expected %0d", out_tuser, exp_row.row));
        if (out_tlast !== exp_row.last)
          report_mismatch($sformatf("row %0d last %b, expected %b",
                                    exp_row.row, out_tlast, exp_row.last));
        for (int j = 0; j < 4; j++)
          if (out_tdata[32 * j +: 32] !== exp_row.cols[32 * j +: 32])
            report_mismatch($sformatf("row %0d col %0d: %h, expected %h", exp_row.row,
                                      j, out_tdata[32 * j +: 32], exp_row.cols[32 * j +: 32]));
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(0, 0, 1'b1, 110);
    test_random_phase(74, 0, 1'b0, 110);
    test_random_phase(0, 74, 1'b1, 110);
    test_random_phase(29, 29, 1'b0, 110);
    wait_idle();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
